[src/mcss_pkg.sv]
// ----------------------------------------------------------------------------
// mcss_pkg
// Shared constants, codes and types of the coding-score scan.
// ----------------------------------------------------------------------------
`default_nettype none

package mcss_pkg;

	localparam int MAX_OLIGO     = 5;
	localparam int POSITION_BITS = 20;
	localparam int FRAME_COUNT   = 3;

	localparam int WIN_DEPTH    = MAX_OLIGO + 1;
	localparam int INI_AW       = 2 * MAX_OLIGO;
	localparam int TRAN_AW      = 2 * WIN_DEPTH;
	localparam int INI_ENTRIES  = 1 << INI_AW;
	localparam int TRAN_ENTRIES = 1 << TRAN_AW;
	localparam int INI_SIZE_W   = INI_AW + 1;
	localparam int TRAN_SIZE_W  = TRAN_AW + 1;
	localparam int COUNT_BITS   = POSITION_BITS + 1;

	localparam int VALUE_W     = 32;
	localparam int SUM_W       = 48;
	localparam int OLIGO_W     = 3;
	localparam int DIGIT_W     = 3;
	localparam int ROW_W       = 2;
	localparam int INDEX_W     = 12;
	localparam int CHAR_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 4;

	// request types, also used as queue entry kinds
	localparam logic [1:0] REQ_INI_WR  = 2'd0;
	localparam logic [1:0] REQ_TRAN_WR = 2'd1;
	localparam logic [1:0] REQ_BASE    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OLIGO     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INI_SIZE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAN_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NULL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_POS  = 3'd4;

	typedef struct packed {
		logic [OLIGO_W-1:0]       oligo_length;
		logic [INI_SIZE_W-1:0]    initial_table_size;
		logic [TRAN_SIZE_W-1:0]   transition_table_size;
		logic signed [VALUE_W-1:0] null_score;
		logic [POSITION_BITS-1:0] last_position;
	} cfg_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic [ROW_W-1:0]         row;
		logic [TRAN_AW-1:0]       waddr;
		logic [VALUE_W-1:0]       wdata;
		logic                     clear;
		logic                     ini_ok;
		logic                     ini_known;
		logic [INI_AW-1:0]        ini_idx;
		logic [POSITION_BITS-1:0] ini_pos;
		logic                     tran_ok;
		logic                     tran_known;
		logic [TRAN_AW-1:0]       tran_idx;
		logic [POSITION_BITS-1:0] tran_pos;
		logic [1:0]               tran_rot;
	} entry_t;

	typedef struct packed {
		logic                      ini_valid;
		logic [POSITION_BITS-1:0]  ini_position;
		logic signed [VALUE_W-1:0] ini_row0;
		logic signed [VALUE_W-1:0] ini_row1;
		logic signed [VALUE_W-1:0] ini_row2;
		logic                      tran_valid;
		logic [POSITION_BITS-1:0]  tran_position;
		logic signed [SUM_W-1:0]   tran_frame0;
		logic signed [SUM_W-1:0]   tran_frame1;
		logic signed [SUM_W-1:0]   tran_frame2;
	} res_t;

endpackage

`default_nettype wire

[src/markov_coding_score_scan.sv]
// ----------------------------------------------------------------------------
// markov_coding_score_scan
// Markov-chain coding-potential scan: table loading, per-position initial
// scores and per-frame running transition sums.
// ----------------------------------------------------------------------------
// One request (a table write or a sequence base) is taken per clock cycle
// while request stall is low. A base that completes a window gives its
// result through a short request queue, a registered read of the per-row
// table memories and the result register; the throughput of one request per
// cycle, while the result side is not stalled, is set by the single read
// port of each table memory and by the per-frame saturating add, both used
// once per base. The tables need no clearing after reset and must be written
// before they are read. Request stall rises only when the result side has
// been stalled long enough to fill the four-entry queue.
`default_nettype none

module markov_coding_score_scan (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [mcss_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [mcss_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                   req_valid,
	output logic                                        req_stall,
	input  wire logic [1:0]                             req_type,
	input  wire logic [mcss_pkg::ROW_W-1:0]             table_row,
	input  wire logic [mcss_pkg::INDEX_W-1:0]           table_index,
	input  wire logic signed [mcss_pkg::VALUE_W-1:0]    table_value,
	input  wire logic [mcss_pkg::CHAR_W-1:0]            base_char,
	input  wire logic                                   first_base,
	output logic                                        res_valid,
	input  wire logic                                   res_stall,
	output logic                                        ini_valid,
	output logic [mcss_pkg::POSITION_BITS-1:0]          ini_position,
	output logic signed [mcss_pkg::VALUE_W-1:0]         ini_row0,
	output logic signed [mcss_pkg::VALUE_W-1:0]         ini_row1,
	output logic signed [mcss_pkg::VALUE_W-1:0]         ini_row2,
	output logic                                        tran_valid,
	output logic [mcss_pkg::POSITION_BITS-1:0]          tran_position,
	output logic signed [mcss_pkg::SUM_W-1:0]           tran_frame0,
	output logic signed [mcss_pkg::SUM_W-1:0]           tran_frame1,
	output logic signed [mcss_pkg::SUM_W-1:0]           tran_frame2
);

	mcss_pkg::cfg_t   cfg_q;
	mcss_pkg::entry_t push_entry;
	mcss_pkg::entry_t head;
	mcss_pkg::res_t   res;

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.oligo_length          <= mcss_pkg::OLIGO_W'(mcss_pkg::MAX_OLIGO);
			cfg_q.initial_table_size    <= mcss_pkg::INI_SIZE_W'(mcss_pkg::INI_ENTRIES);
			cfg_q.transition_table_size <= mcss_pkg::TRAN_SIZE_W'(mcss_pkg::TRAN_ENTRIES);
			cfg_q.null_score            <= '0;
			cfg_q.last_position         <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mcss_pkg::CFG_OLIGO:
					cfg_q.oligo_length <= cfg_data[mcss_pkg::OLIGO_W-1:0];
				mcss_pkg::CFG_INI_SIZE:
					cfg_q.initial_table_size <= cfg_data[mcss_pkg::INI_SIZE_W-1:0];
				mcss_pkg::CFG_TRAN_SIZE:
					cfg_q.transition_table_size <= cfg_data[mcss_pkg::TRAN_SIZE_W-1:0];
				mcss_pkg::CFG_NULL:
					cfg_q.null_score <= cfg_data[mcss_pkg::VALUE_W-1:0];
				mcss_pkg::CFG_LAST_POS:
					cfg_q.last_position <= cfg_data[mcss_pkg::POSITION_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	mcss_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.req_type    (req_type),
		.table_row   (table_row),
		.table_index (table_index),
		.table_value (table_value),
		.base_char   (base_char),
		.first_base  (first_base),
		.push        (push),
		.entry       (push_entry)
	);

	mcss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	mcss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.null_score (cfg_q.null_score),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.res_stall  (res_stall),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign ini_valid     = res.ini_valid;
	assign ini_position  = res.ini_position;
	assign ini_row0      = res.ini_row0;
	assign ini_row1      = res.ini_row1;
	assign ini_row2      = res.ini_row2;
	assign tran_valid    = res.tran_valid;
	assign tran_position = res.tran_position;
	assign tran_frame0   = res.tran_frame0;
	assign tran_frame1   = res.tran_frame1;
	assign tran_frame2   = res.tran_frame2;

endmodule

`default_nettype wire

[src/mcss_front.sv]
// ----------------------------------------------------------------------------
// mcss_front
// Accepts requests, keeps the digit window and base count, and turns each
// base into table indexes, known flags and window positions.
// ----------------------------------------------------------------------------
`default_nettype none

module mcss_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mcss_pkg::cfg_t                      cfg,
	input  wire logic                                accept,
	input  wire logic [1:0]                          req_type,
	input  wire logic [mcss_pkg::ROW_W-1:0]          table_row,
	input  wire logic [mcss_pkg::INDEX_W-1:0]        table_index,
	input  wire logic [mcss_pkg::VALUE_W-1:0]        table_value,
	input  wire logic [mcss_pkg::CHAR_W-1:0]         base_char,
	input  wire logic                                first_base,
	output logic                                     push,
	output mcss_pkg::entry_t                         entry
);

	localparam logic [mcss_pkg::DIGIT_W-1:0] DIGIT_A = 3'd0;
	localparam logic [mcss_pkg::DIGIT_W-1:0] DIGIT_C = 3'd1;
	localparam logic [mcss_pkg::DIGIT_W-1:0] DIGIT_G = 3'd2;
	localparam logic [mcss_pkg::DIGIT_W-1:0] DIGIT_T = 3'd3;
	localparam logic [mcss_pkg::DIGIT_W-1:0] DIGIT_N = 3'd4;
	localparam logic [mcss_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

	function automatic logic [mcss_pkg::DIGIT_W-1:0] digit_of(
		input logic [mcss_pkg::CHAR_W-1:0] c
	);
		logic [mcss_pkg::DIGIT_W-1:0] d;
		unique case (c)
			"A", "a": d = DIGIT_A;
			"C", "c": d = DIGIT_C;
			"G", "g": d = DIGIT_G;
			"T", "t", "U", "u": d = DIGIT_T;
			default: d = DIGIT_N;
		endcase
		return d;
	endfunction

	logic [mcss_pkg::DIGIT_W-1:0]    win_q [mcss_pkg::WIN_DEPTH];
	logic [mcss_pkg::DIGIT_W-1:0]    win_d [mcss_pkg::WIN_DEPTH];
	logic [mcss_pkg::COUNT_BITS-1:0] cnt_q;
	logic [1:0]                      m3_q;

	logic                            is_base;
	logic [mcss_pkg::COUNT_BITS-1:0] p;
	logic [1:0]                      pm3;
	logic [mcss_pkg::OLIGO_W-1:0]    k;
	logic [mcss_pkg::OLIGO_W-1:0]    km1;
	logic [mcss_pkg::COUNT_BITS-1:0] pi_full;
	logic [mcss_pkg::COUNT_BITS-1:0] pt_full;
	logic [mcss_pkg::COUNT_BITS-1:0] last_ext;
	logic [mcss_pkg::INI_AW-1:0]     ini_idx;
	logic [mcss_pkg::TRAN_AW-1:0]    tran_idx;
	logic                            ini_unk;
	logic                            tran_unk;
	logic [3:0]                      rot_v;
	logic                            wr_ok;

	assign is_base = (req_type == mcss_pkg::REQ_BASE);
	assign p       = first_base ? '0 : cnt_q;
	assign pm3     = first_base ? '0 : m3_q;

	always_comb begin
		if (cfg.oligo_length == '0) begin
			k = mcss_pkg::OLIGO_W'(1);
		end else if (cfg.oligo_length > mcss_pkg::OLIGO_W'(mcss_pkg::MAX_OLIGO)) begin
			k = mcss_pkg::OLIGO_W'(mcss_pkg::MAX_OLIGO);
		end else begin
			k = cfg.oligo_length;
		end
	end

	assign km1 = k - mcss_pkg::OLIGO_W'(1);

	always_comb begin
		win_d[0] = digit_of(base_char);
		for (int j = 1; j < mcss_pkg::WIN_DEPTH; j++) begin
			win_d[j] = first_base ? '0 : win_q[j-1];
		end
	end

	always_comb begin
		ini_idx  = '0;
		tran_idx = '0;
		ini_unk  = 1'b0;
		tran_unk = 1'b0;
		for (int j = 0; j < mcss_pkg::MAX_OLIGO; j++) begin
			if (j < int'(k)) begin
				ini_idx[2*j +: 2] = win_d[j][1:0];
				ini_unk = ini_unk | win_d[j][2];
			end
		end
		for (int j = 0; j < mcss_pkg::WIN_DEPTH; j++) begin
			if (j <= int'(k)) begin
				tran_idx[2*j +: 2] = win_d[j][1:0];
				tran_unk = tran_unk | win_d[j][2];
			end
		end
	end

	// row rotation of the transition window start, (p - k) mod 3
	always_comb begin
		rot_v = 4'(pm3) + 4'(2 * mcss_pkg::FRAME_COUNT) - 4'(k);
		if (rot_v >= 4'(2 * mcss_pkg::FRAME_COUNT)) begin
			rot_v = rot_v - 4'(2 * mcss_pkg::FRAME_COUNT);
		end
		if (rot_v >= 4'(mcss_pkg::FRAME_COUNT)) begin
			rot_v = rot_v - 4'(mcss_pkg::FRAME_COUNT);
		end
	end

	assign last_ext = mcss_pkg::COUNT_BITS'(cfg.last_position);
	assign pi_full  = p - mcss_pkg::COUNT_BITS'(km1);
	assign pt_full  = p - mcss_pkg::COUNT_BITS'(k);

	always_comb begin
		entry            = '0;
		entry.kind       = req_type;
		entry.row        = table_row;
		entry.waddr      = mcss_pkg::TRAN_AW'(table_index);
		entry.wdata      = table_value;
		entry.clear      = first_base;
		entry.ini_ok     = (p >= mcss_pkg::COUNT_BITS'(km1)) && (pi_full <= last_ext);
		entry.ini_known  = !ini_unk
			&& (mcss_pkg::INI_SIZE_W'(ini_idx) < cfg.initial_table_size);
		entry.ini_idx    = ini_idx;
		entry.ini_pos    = pi_full[mcss_pkg::POSITION_BITS-1:0];
		entry.tran_ok    = (p >= mcss_pkg::COUNT_BITS'(k)) && (pt_full <= last_ext);
		entry.tran_known = !tran_unk
			&& (mcss_pkg::TRAN_SIZE_W'(tran_idx) < cfg.transition_table_size);
		entry.tran_idx   = tran_idx;
		entry.tran_pos   = pt_full[mcss_pkg::POSITION_BITS-1:0];
		entry.tran_rot   = rot_v[1:0];
	end

	always_comb begin
		unique case (req_type)
			mcss_pkg::REQ_INI_WR: wr_ok = (table_row < mcss_pkg::ROW_W'(mcss_pkg::FRAME_COUNT))
				&& (int'(table_index) < mcss_pkg::INI_ENTRIES);
			mcss_pkg::REQ_TRAN_WR: wr_ok = (table_row < mcss_pkg::ROW_W'(mcss_pkg::FRAME_COUNT))
				&& (int'(table_index) < mcss_pkg::TRAN_ENTRIES);
			mcss_pkg::REQ_BASE: wr_ok = 1'b1;
			default: wr_ok = 1'b0;
		endcase
	end

	assign push = accept && wr_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < mcss_pkg::WIN_DEPTH; j++) begin
				win_q[j] <= '0;
			end
			cnt_q <= '0;
			m3_q  <= '0;
		end else if (accept && is_base) begin
			win_q <= win_d;
			if (p != COUNT_MAX) begin
				cnt_q <= p + mcss_pkg::COUNT_BITS'(1);
				m3_q  <= (pm3 == 2'(mcss_pkg::FRAME_COUNT - 1)) ? 2'd0 : pm3 + 2'd1;
			end else begin
				cnt_q <= p;
				m3_q  <= pm3;
			end
		end
	end

endmodule

`default_nettype wire

[src/mcss_queue.sv]
// ----------------------------------------------------------------------------
// mcss_queue
// Short first-in first-out queue of classified requests between the front
// and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mcss_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire mcss_pkg::entry_t push_entry,
	input  wire logic             pop,
	output mcss_pkg::entry_t      head,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = $clog2(mcss_pkg::QUEUE_DEPTH);

	mcss_pkg::entry_t mem_q [mcss_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W+1)'(mcss_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(mcss_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(mcss_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + (PTR_W+1)'(1);
				2'b01: cnt_q <= cnt_q - (PTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/mcss_back.sv]
// ----------------------------------------------------------------------------
// mcss_back
// Table memories, score lookup, per-frame saturating sums and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcss_back (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic signed [mcss_pkg::VALUE_W-1:0]   null_score,
	input  wire mcss_pkg::entry_t                      head,
	input  wire logic                                  q_empty,
	output logic                                       pop,
	input  wire logic                                  res_stall,
	output logic                                       res_valid,
	output mcss_pkg::res_t                             res
);

	localparam logic signed [mcss_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(mcss_pkg::SUM_W-1){1'b1}}};
	localparam logic signed [mcss_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(mcss_pkg::SUM_W-1){1'b0}}};

	logic signed [mcss_pkg::VALUE_W-1:0] ini_rd  [mcss_pkg::FRAME_COUNT];
	logic signed [mcss_pkg::VALUE_W-1:0] tran_rd [mcss_pkg::FRAME_COUNT];
	logic signed [mcss_pkg::VALUE_W-1:0] ini_sc  [mcss_pkg::FRAME_COUNT];
	logic signed [mcss_pkg::SUM_W-1:0]   sum_q   [mcss_pkg::FRAME_COUNT];
	logic signed [mcss_pkg::SUM_W-1:0]   sum_d   [mcss_pkg::FRAME_COUNT];

	mcss_pkg::entry_t s1_q;
	logic             s1_valid_s1;
	logic             res_valid_q;
	mcss_pkg::res_t   res_q;

	logic s1_res;
	logic out_free;
	logic s1_move;
	logic s1_ready;
	logic pop_base;

	assign s1_res   = s1_q.ini_ok || s1_q.tran_ok;
	assign out_free = !res_valid_q || !res_stall;
	assign s1_move  = s1_valid_s1 && (!s1_res || out_free);
	assign s1_ready = !s1_valid_s1 || s1_move;
	assign pop      = !q_empty && s1_ready;
	assign pop_base = pop && (head.kind == mcss_pkg::REQ_BASE);

	for (genvar r = 0; r < mcss_pkg::FRAME_COUNT; r++) begin : g_row
		logic [mcss_pkg::VALUE_W-1:0] ini_mem  [mcss_pkg::INI_ENTRIES];
		logic [mcss_pkg::VALUE_W-1:0] tran_mem [mcss_pkg::TRAN_ENTRIES];
		logic [mcss_pkg::VALUE_W-1:0] ini_rd_s1;
		logic [mcss_pkg::VALUE_W-1:0] tran_rd_s1;

		always_ff @(posedge clk) begin
			if (pop && head.kind == mcss_pkg::REQ_INI_WR
				&& head.row == mcss_pkg::ROW_W'(r)) begin
				ini_mem[head.waddr[mcss_pkg::INI_AW-1:0]] <= head.wdata;
			end
			if (pop && head.kind == mcss_pkg::REQ_TRAN_WR
				&& head.row == mcss_pkg::ROW_W'(r)) begin
				tran_mem[head.waddr] <= head.wdata;
			end
			if (pop_base) begin
				ini_rd_s1  <= ini_mem[head.ini_idx];
				tran_rd_s1 <= tran_mem[head.tran_idx];
			end
		end

		assign ini_rd[r]  = ini_rd_s1;
		assign tran_rd[r] = tran_rd_s1;
	end

	always_ff @(posedge clk) begin
		if (pop_base) begin
			s1_q <= head;
		end
	end

	always_comb begin
		logic [2:0]                          sel;
		logic signed [mcss_pkg::VALUE_W-1:0] tsc;
		logic signed [mcss_pkg::SUM_W-1:0]   base;
		logic signed [mcss_pkg::SUM_W:0]     wide;
		for (int x = 0; x < mcss_pkg::FRAME_COUNT; x++) begin
			ini_sc[x] = s1_q.ini_known ? ini_rd[x] : null_score;
			// frame x reads row (3 - x + start) mod 3
			sel = 3'(s1_q.tran_rot)
				+ 3'((mcss_pkg::FRAME_COUNT - x) % mcss_pkg::FRAME_COUNT);
			if (sel >= 3'(mcss_pkg::FRAME_COUNT)) begin
				sel = sel - 3'(mcss_pkg::FRAME_COUNT);
			end
			unique case (sel[1:0])
				2'd1: tsc = tran_rd[1];
				2'd2: tsc = tran_rd[2];
				default: tsc = tran_rd[0];
			endcase
			if (!s1_q.tran_known) begin
				tsc = null_score;
			end
			base = s1_q.clear ? '0 : sum_q[x];
			wide = (mcss_pkg::SUM_W+1)'(base) + (mcss_pkg::SUM_W+1)'(tsc);
			if (!s1_q.tran_ok) begin
				sum_d[x] = base;
			end else if (wide[mcss_pkg::SUM_W] != wide[mcss_pkg::SUM_W-1]) begin
				sum_d[x] = wide[mcss_pkg::SUM_W] ? SUM_MIN : SUM_MAX;
			end else begin
				sum_d[x] = wide[mcss_pkg::SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			for (int x = 0; x < mcss_pkg::FRAME_COUNT; x++) begin
				sum_q[x] <= '0;
			end
		end else begin
			if (s1_ready) begin
				s1_valid_s1 <= pop_base;
			end
			if (out_free) begin
				res_valid_q <= s1_valid_s1 && s1_res;
			end
			if (s1_move) begin
				sum_q <= sum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && s1_res) begin
			res_q.ini_valid     <= s1_q.ini_ok;
			res_q.ini_position  <= s1_q.ini_ok ? s1_q.ini_pos : '0;
			res_q.ini_row0      <= s1_q.ini_ok ? ini_sc[0] : '0;
			res_q.ini_row1      <= s1_q.ini_ok ? ini_sc[1] : '0;
			res_q.ini_row2      <= s1_q.ini_ok ? ini_sc[2] : '0;
			res_q.tran_valid    <= s1_q.tran_ok;
			res_q.tran_position <= s1_q.tran_ok ? s1_q.tran_pos : '0;
			res_q.tran_frame0   <= s1_q.tran_ok ? sum_d[0] : '0;
			res_q.tran_frame1   <= s1_q.tran_ok ? sum_d[1] : '0;
			res_q.tran_frame2   <= s1_q.tran_ok ? sum_d[2] : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

[src/mcss_checker.sv]
// ----------------------------------------------------------------------------
// mcss_checker
// Port-level checks of the coding-score scan, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcss_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                res_valid,
	input  wire logic                                res_stall,
	input  wire logic                                ini_valid,
	input  wire logic [mcss_pkg::POSITION_BITS-1:0]  ini_position,
	input  wire logic signed [mcss_pkg::VALUE_W-1:0] ini_row0,
	input  wire logic signed [mcss_pkg::VALUE_W-1:0] ini_row1,
	input  wire logic signed [mcss_pkg::VALUE_W-1:0] ini_row2,
	input  wire logic                                tran_valid,
	input  wire logic [mcss_pkg::POSITION_BITS-1:0]  tran_position,
	input  wire logic signed [mcss_pkg::SUM_W-1:0]   tran_frame0,
	input  wire logic signed [mcss_pkg::SUM_W-1:0]   tran_frame1,
	input  wire logic signed [mcss_pkg::SUM_W-1:0]   tran_frame2
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(ini_position)
			&& $stable(tran_position) && $stable(tran_frame0) && $stable(ini_row0))
		else $error("stalled result changed");

	a_res_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ini_valid || tran_valid)
		else $error("result without any valid part");

	a_ini_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !ini_valid |-> ini_position == '0 && ini_row0 == '0
			&& ini_row1 == '0 && ini_row2 == '0)
		else $error("initial fields not cleared");

	a_tran_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !tran_valid |-> tran_position == '0 && tran_frame0 == '0
			&& tran_frame1 == '0 && tran_frame2 == '0)
		else $error("transition fields not cleared");

	// initial window starts one base after the transition window
	a_pos_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ini_valid && tran_valid
			|-> ini_position == tran_position + mcss_pkg::POSITION_BITS'(1))
		else $error("window positions out of step");

endmodule

bind markov_coding_score_scan mcss_checker u_mcss_checker (.*);

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the coding-score scan. Table loads, sequence
// bases and unused requests go in through the request channel while the
// bench keeps its own scoring of every accepted request and checks each
// returned score set field by field. The register settings change between
// phases, and both ends idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mcss_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam bit [DIGIT_W-1:0] DIGIT_UNKNOWN = 3'd4;
	localparam int POS_MAX = (1 << POSITION_BITS) - 1;
	localparam int SLOT_MAX = (1 << INDEX_W) - 1;
	localparam int COUNT_LIMIT = (1 << COUNT_BITS) - 1;
	localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam int SETTLE = 4;
	localparam int PRESSURE_PHASE = 5;
	localparam int PRINT_LIMIT = 50;
	localparam int CYCLE_LIMIT = 1000000;

	typedef bit [DIGIT_W-1:0] window_t [WIN_DEPTH];

	typedef struct {
		bit [1:0]                kind;
		bit [ROW_W-1:0]          row;
		bit [INDEX_W-1:0]        slot;
		bit signed [VALUE_W-1:0] weight;
		bit [CHAR_W-1:0]         ch;
		bit                      first;
	} req_item_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] req_type = '0;
	logic [ROW_W-1:0] table_row = '0;
	logic [INDEX_W-1:0] table_index = '0;
	logic signed [VALUE_W-1:0] table_value = '0;
	logic [CHAR_W-1:0] base_char = '0;
	logic first_base = 1'b0;
	logic res_valid;
	logic res_stall = 1'b1;
	logic ini_valid;
	logic [POSITION_BITS-1:0] ini_position;
	logic signed [VALUE_W-1:0] ini_row0;
	logic signed [VALUE_W-1:0] ini_row1;
	logic signed [VALUE_W-1:0] ini_row2;
	logic tran_valid;
	logic [POSITION_BITS-1:0] tran_position;
	logic signed [SUM_W-1:0] tran_frame0;
	logic signed [SUM_W-1:0] tran_frame1;
	logic signed [SUM_W-1:0] tran_frame2;

	markov_coding_score_scan u_dut (.*);

	// register copy, shared by the generator and the scoring
	bit [OLIGO_W-1:0] cfg_oligo = 3'd5;
	int cfg_ini_size = INI_ENTRIES;
	int cfg_tran_size = TRAN_ENTRIES;
	bit signed [VALUE_W-1:0] cfg_null = '0;
	int cfg_last = POS_MAX;

	// scoring state, advanced on accepted requests
	bit signed [VALUE_W-1:0] ini_table [FRAME_COUNT][INI_ENTRIES];
	bit signed [VALUE_W-1:0] tran_table [FRAME_COUNT][TRAN_ENTRIES];
	window_t scan_win = '{default: 3'd0};
	int scan_count = 0;
	longint frame_sum [FRAME_COUNT] = '{default: 0};
	res_t due_scores [$];

	// generator state, runs ahead of the block
	bit ini_loaded [FRAME_COUNT][INI_ENTRIES];
	bit tran_loaded [FRAME_COUNT][TRAN_ENTRIES];
	window_t gen_win = '{default: 3'd0};
	int gen_count = 0;
	int frag_left = 0;
	bit [7:0] base_letters [10] = '{"A", "C", "G", "T", "U", "a", "c", "g", "t", "u"};

	req_item_t pending_reqs [$];
	req_item_t next_req;
	req_item_t seen_req;
	int n_queued = 0;
	int n_taken = 0;
	bit req_took = 1'b0;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_on = 1'b0;
	int phase_no = 0;
	int mismatches = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit [DIGIT_W-1:0] base_digit(input bit [CHAR_W-1:0] c);
		case (c)
			"A", "a": return 3'd0;
			"C", "c": return 3'd1;
			"G", "g": return 3'd2;
			"T", "t", "U", "u": return 3'd3;
			default: return DIGIT_UNKNOWN;
		endcase
	endfunction

	// newest digit least significant; fails on any unknown digit
	function automatic bit pack_window(input window_t w, input int len, output int code);
		code = 0;
		for (int j = len; j > 0; j--) begin
			if (w[j-1] > 3) return 1'b0;
			code = (code << 2) | int'(w[j-1]);
		end
		return 1'b1;
	endfunction

	function automatic int eff_oligo();
		if (cfg_oligo == 0) return 1;
		if (cfg_oligo > MAX_OLIGO) return MAX_OLIGO;
		return int'(cfg_oligo);
	endfunction

	function automatic longint sum_sat(input longint t);
		if (t > SUM_MAX) return SUM_MAX;
		if (t < SUM_MIN) return SUM_MIN;
		return t;
	endfunction

	task automatic score_request(input req_item_t rq);
		int k;
		int p;
		int code;
		int r;
		bit known;
		res_t want;
		case (rq.kind)
			REQ_INI_WR: begin
				if (rq.row < FRAME_COUNT && rq.slot < INI_ENTRIES)
					ini_table[rq.row][rq.slot] = rq.weight;
			end
			REQ_TRAN_WR: begin
				if (rq.row < FRAME_COUNT)
					tran_table[rq.row][rq.slot] = rq.weight;
			end
			REQ_BASE: begin
				if (rq.first) begin
					scan_win = '{default: 3'd0};
					scan_count = 0;
					frame_sum = '{default: 0};
				end
				for (int j = WIN_DEPTH - 1; j > 0; j--)
					scan_win[j] = scan_win[j-1];
				scan_win[0] = base_digit(rq.ch);
				p = scan_count;
				if (scan_count < COUNT_LIMIT)
					scan_count++;
				k = eff_oligo();
				want = '0;
				if (p + 1 >= k && p - (k - 1) <= cfg_last) begin
					known = pack_window(scan_win, k, code) && code < cfg_ini_size;
					want.ini_valid = 1'b1;
					want.ini_position = POSITION_BITS'(p - (k - 1));
					want.ini_row0 = known ? ini_table[0][code] : cfg_null;
					want.ini_row1 = known ? ini_table[1][code] : cfg_null;
					want.ini_row2 = known ? ini_table[2][code] : cfg_null;
				end
				if (p >= k && p - k <= cfg_last) begin
					known = pack_window(scan_win, k + 1, code) && code < cfg_tran_size;
					want.tran_valid = 1'b1;
					want.tran_position = POSITION_BITS'(p - k);
					for (int x = 0; x < FRAME_COUNT; x++) begin
						r = (3 - x + p - k) % 3;
						frame_sum[x] = sum_sat(frame_sum[x] + (known ?
							longint'(tran_table[r][code]) : longint'(cfg_null)));
					end
					want.tran_frame0 = frame_sum[0][SUM_W-1:0];
					want.tran_frame1 = frame_sum[1][SUM_W-1:0];
					want.tran_frame2 = frame_sum[2][SUM_W-1:0];
				end
				if (want.ini_valid || want.tran_valid)
					due_scores.push_back(want);
			end
			default: ;
		endcase
	endtask

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	task automatic field_check(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic check_scores();
		res_t want;
		if (due_scores.size() == 0) begin
			report("score result with nothing expected");
			return;
		end
		want = due_scores.pop_front();
		field_check("ini_valid", ini_valid, want.ini_valid);
		field_check("ini_position", ini_position, want.ini_position);
		field_check("ini_row0", ini_row0, want.ini_row0);
		field_check("ini_row1", ini_row1, want.ini_row1);
		field_check("ini_row2", ini_row2, want.ini_row2);
		field_check("tran_valid", tran_valid, want.tran_valid);
		field_check("tran_position", tran_position, want.tran_position);
		field_check("tran_frame0", tran_frame0, want.tran_frame0);
		field_check("tran_frame1", tran_frame1, want.tran_frame1);
		field_check("tran_frame2", tran_frame2, want.tran_frame2);
	endtask

	// request generation
	function automatic req_item_t blank_req(input bit [1:0] kind);
		req_item_t r;
		r.kind = kind;
		r.row = ROW_W'($urandom_range(3));
		r.slot = INDEX_W'($urandom);
		r.weight = $urandom;
		r.ch = CHAR_W'($urandom);
		r.first = 1'($urandom_range(1));
		return r;
	endfunction

	function automatic bit [VALUE_W-1:0] rand_weight();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_row();
		return ($urandom_range(15) == 0) ? 3 : $urandom_range(FRAME_COUNT - 1);
	endfunction

	function automatic bit [CHAR_W-1:0] rand_char();
		if ($urandom_range(9) == 0)
			return CHAR_W'($urandom);
		return base_letters[$urandom_range(9)];
	endfunction

	task automatic queue_req(input req_item_t r);
		pending_reqs.push_back(r);
		n_queued++;
	endtask

	task automatic add_write(input bit [1:0] kind, input int row, input int slot,
			input bit [VALUE_W-1:0] w);
		req_item_t r;
		r = blank_req(kind);
		r.row = ROW_W'(row);
		r.slot = INDEX_W'(slot);
		r.weight = w;
		if (row < FRAME_COUNT) begin
			if (kind == REQ_INI_WR && slot < INI_ENTRIES)
				ini_loaded[row][slot] = 1'b1;
			if (kind == REQ_TRAN_WR)
				tran_loaded[row][slot] = 1'b1;
		end
		queue_req(r);
	endtask

	task automatic add_noise();
		queue_req(blank_req(REQ_UNUSED));
	endtask

	// loads any table entry the base is about to look up, then sends the base
	task automatic add_base(input bit [CHAR_W-1:0] ch, input bit first);
		int k;
		int code;
		req_item_t r;
		if (first) begin
			gen_win = '{default: 3'd0};
			gen_count = 0;
		end
		for (int j = WIN_DEPTH - 1; j > 0; j--)
			gen_win[j] = gen_win[j-1];
		gen_win[0] = base_digit(ch);
		k = eff_oligo();
		if (gen_count + 1 >= k && pack_window(gen_win, k, code) && code < cfg_ini_size)
			for (int row = 0; row < FRAME_COUNT; row++)
				if (!ini_loaded[row][code])
					add_write(REQ_INI_WR, row, code, rand_weight());
		if (gen_count >= k && pack_window(gen_win, k + 1, code) && code < cfg_tran_size)
			for (int row = 0; row < FRAME_COUNT; row++)
				if (!tran_loaded[row][code])
					add_write(REQ_TRAN_WR, row, code, rand_weight());
		gen_count++;
		r = blank_req(REQ_BASE);
		r.ch = ch;
		r.first = first;
		queue_req(r);
	endtask

	task automatic random_reqs(input int n);
		int pick;
		bit first;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				first = (frag_left == 0);
				if (first)
					frag_left = ($urandom_range(9) == 0) ? $urandom_range(100, 250) :
						$urandom_range(1, 40);
				frag_left--;
				add_base(rand_char(), first);
			end else if (pick < 88) begin
				if ($urandom_range(1))
					add_write(REQ_INI_WR, rand_row(), ($urandom_range(15) == 0) ?
						$urandom_range(INI_ENTRIES, SLOT_MAX) :
						$urandom_range(INI_ENTRIES - 1), rand_weight());
				else
					add_write(REQ_TRAN_WR, rand_row(), $urandom_range(SLOT_MAX),
						rand_weight());
			end else if (pick < 94) begin
				add_noise();
			end else begin
				// fragment cut short
				frag_left = $urandom_range(1, 40);
				add_base(rand_char(), 1'b1);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic set_cfg(input bit [OLIGO_W-1:0] k, input int ini_size, input int tran_size,
			input bit [VALUE_W-1:0] nul, input int last);
		write_reg(CFG_OLIGO, CFG_DATA_W'(k));
		write_reg(CFG_INI_SIZE, CFG_DATA_W'(ini_size));
		write_reg(CFG_TRAN_SIZE, CFG_DATA_W'(tran_size));
		write_reg(CFG_NULL, nul);
		write_reg(CFG_LAST_POS, CFG_DATA_W'(last));
		cfg_we <= 1'b0;
		cfg_oligo = k;
		cfg_ini_size = ini_size;
		cfg_tran_size = tran_size;
		cfg_null = nul;
		cfg_last = last;
		phase_no++;
	endtask

	task automatic drain();
		while (n_taken != n_queued || due_scores.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_took)) begin
			if (pending_reqs.size() != 0 && (hold_on || $urandom_range(99) >= send_idle)) begin
				next_req = pending_reqs.pop_front();
				req_valid <= 1'b1;
				req_type <= next_req.kind;
				table_row <= next_req.row;
				table_index <= next_req.slot;
				table_value <= next_req.weight;
				base_char <= next_req.ch;
				first_base <= next_req.first;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result side stall
	always @(negedge clk)
		res_stall <= hold_on || ($urandom_range(99) < recv_idle);

	// monitor: scores accepted requests, checks accepted results
	always @(posedge clk) begin
		req_took = arst_n && req_valid && !req_stall;
		if (req_took) begin
			seen_req.kind = req_type;
			seen_req.row = table_row;
			seen_req.slot = table_index;
			seen_req.weight = table_value;
			seen_req.ch = base_char;
			seen_req.first = first_base;
			score_request(seen_req);
			n_taken++;
		end
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0)
			check_scores();
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// long result stall so the request queue fills and backs up
	initial begin
		wait (phase_no == PRESSURE_PHASE);
		repeat (20) @(posedge clk);
		hold_on = 1'b1;
		repeat (100) @(posedge clk);
		hold_on = 1'b0;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		send_idle = 8;
		recv_idle = 84;
		set_cfg(3'd1, INI_ENTRIES, TRAN_ENTRIES, 32'h8000_0000, POS_MAX);
		add_write(REQ_INI_WR, 0, 0, 32'h7FFF_FFFF);
		add_write(REQ_INI_WR, 1, 0, 32'h8000_0000);
		add_write(REQ_INI_WR, 2, 0, 32'h0000_0000);
		add_write(REQ_INI_WR, 3, 5, 32'h1234_5678);
		add_write(REQ_INI_WR, 0, SLOT_MAX, 32'hFFFF_FFFF);
		add_write(REQ_TRAN_WR, 3, 0, 32'h0000_0001);
		add_write(REQ_TRAN_WR, 2, SLOT_MAX, 32'hFFFF_FFFF);
		add_noise();
		add_base("A", 1'b1);
		add_base("c", 1'b0);
		add_base("G", 1'b0);
		add_base("t", 1'b0);
		add_base("U", 1'b0);
		add_base("u", 1'b0);
		add_base("N", 1'b0);
		add_base(8'hFF, 1'b0);
		add_base(8'h00, 1'b0);
		add_base("a", 1'b0);
		add_base("C", 1'b0);
		add_base("g", 1'b0);
		add_base("T", 1'b0);
		add_base("A", 1'b1);
		add_base("A", 1'b0);
		drain();

		set_cfg(3'd0, 4, 16, $urandom, POS_MAX);
		random_reqs(230);
		drain();
		set_cfg(3'd2, 1, 1, 32'h7FFF_FFFF, 40);
		random_reqs(230);
		drain();

		send_idle = 84;
		recv_idle = 8;
		set_cfg(3'd5, INI_ENTRIES, TRAN_ENTRIES, $urandom, POS_MAX);
		random_reqs(110);
		drain();
		set_cfg(3'd7, 600, 2500, $urandom, 0);
		random_reqs(110);
		drain();

		send_idle = 0;
		recv_idle = 0;
		set_cfg(3'd3, 50, 200, $urandom, 25);
		random_reqs(140);
		drain();
		set_cfg(3'd6, $urandom_range(1, INI_ENTRIES), $urandom_range(1, TRAN_ENTRIES),
			$urandom, $urandom_range(1, 200));
		random_reqs(140);
		drain();

		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

[markov_coding_score_scan.f]
src/mcss_pkg.sv
src/mcss_front.sv
src/mcss_queue.sv
src/mcss_back.sv
src/markov_coding_score_scan.sv
src/mcss_checker.sv
sim/tb.sv
